### rtl/qsu_pkg.sv
// Shared types, constants and the escape decoder of the quoted string unescaper.
package qsu_pkg;

    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;

    typedef enum logic [3:0] {
        PH_BEFORE = 4'b0001,
        PH_INSIDE = 4'b0010,
        PH_ESCAPE = 4'b0100,
        PH_AFTER  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_STRING = 2'd1,
        ST_BAD_ESCAPE = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] word_position;
        logic        end_of_string;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_escape;

    function automatic t_escape decode_escape(input logic [7:0] c);
        t_escape e;
        e.hit = 1'b1;
        unique case (c)
            8'h61:        e.value = 8'd7;
            8'h62:        e.value = 8'd8;
            8'h65:        e.value = 8'd27;
            8'h66:        e.value = 8'd12;
            8'h6e:        e.value = 8'd10;
            8'h72:        e.value = 8'd13;
            8'h74:        e.value = 8'd9;
            8'h76:        e.value = 8'd11;
            CH_BACKSLASH: e.value = 8'd92;
            CH_QUOTE:     e.value = 8'd34;
            default: begin
                e.hit   = 1'b0;
                e.value = 8'd0;
            end
        endcase
        return e;
    endfunction

endpackage

### rtl/qsu_res_fifo.sv
// Result queue that takes up to two result words per cycle and gives out one.
module qsu_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qsu_pkg::t_push   i_push0,
    input  qsu_pkg::t_push   i_push1,
    output logic             o_room2,
    output logic             o_valid,
    output qsu_pkg::t_result o_data,
    input  logic             i_pop
);
    import qsu_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_count;
    logic [FIFO_AW-1:0]   wr_next;
    logic                 pop;
    logic [FIFO_AW:0]     n_count;

    assign wr_next = r_wr + FIFO_AW'(1);
    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign n_count = r_count + (FIFO_AW + 1)'(i_push0.valid) + (FIFO_AW + 1)'(i_push1.valid)
                     - (FIFO_AW + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push0.valid) begin
            r_mem[r_wr] <= i_push0.data;
        end
        if (i_push1.valid) begin
            r_mem[wr_next] <= i_push1.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push0.valid) + FIFO_AW'(i_push1.valid);
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_count <= n_count;
        end
    end

endmodule

### rtl/quoted_string_unescaper_core.sv
// Top level of the quoted string unescaper: byte parser and result output stream.
//
// Decodes the bytes of one quoted string operand, one byte per clock while
// the input is ready. Each accepted byte is parsed in the same cycle and its
// result words (none, one, or two when a character and the terminator fall on
// the last byte) go into a four-word result queue. The input is ready while
// the queue has room for two words, so with a consumer that takes a word
// every cycle the block sustains one byte per cycle; a last byte that yields
// two words puts both in the queue at once. Words leave in order, one per
// cycle while the consumer is ready, and none leaves in the cycle its byte
// is accepted. On an error the final word carries the string's start
// position so the consumer can drop the words already given.
module quoted_string_unescaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [23:8] word_position
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import qsu_pkg::*;

    t_phase      r_phase;
    t_status     r_err;
    logic [15:0] r_pos;
    logic [15:0] r_start;
    t_phase      n_phase;
    t_status     n_err;
    logic [15:0] n_pos;
    logic [15:0] n_start;

    logic        accept;
    logic        room2;
    t_escape     esc;
    t_push       chr;
    t_push       fin;
    t_push       push0;
    t_push       push1;
    t_status     fin_st;
    t_result     head;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = room2;
    assign esc             = decode_escape(i_s_axis_tdata);

    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_pos   = r_pos;
        n_start = r_start;
        fin_st  = ST_OK;
        chr     = '0;
        fin     = '0;
        if (accept) begin
            if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_BEFORE: begin
                        if (i_s_axis_tdata == CH_QUOTE) begin
                            n_phase = PH_INSIDE;
                        end else if (i_s_axis_tdata != CH_SPACE && i_s_axis_tdata != CH_TAB) begin
                            n_err = ST_BAD_STRING;
                        end
                    end
                    PH_INSIDE: begin
                        if (i_s_axis_tdata == CH_QUOTE) begin
                            n_phase = PH_AFTER;
                        end else if (i_s_axis_tdata == CH_BACKSLASH) begin
                            n_phase = PH_ESCAPE;
                        end else begin
                            chr.valid = 1'b1;
                            chr.data  = '{i_s_axis_tdata, r_pos, 1'b0, ST_OK};
                            n_pos     = r_pos + 16'd1;
                        end
                    end
                    PH_ESCAPE: begin
                        if (esc.hit) begin
                            chr.valid = 1'b1;
                            chr.data  = '{esc.value, r_pos, 1'b0, ST_OK};
                            n_pos     = r_pos + 16'd1;
                            n_phase   = PH_INSIDE;
                        end else begin
                            n_err = ST_BAD_ESCAPE;
                        end
                    end
                    PH_AFTER: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tlast) begin
                fin_st = n_err;
                if (fin_st == ST_OK && n_phase != PH_AFTER) begin
                    fin_st = ST_BAD_STRING;
                end
                fin.valid = 1'b1;
                if (fin_st == ST_OK) begin
                    fin.data = '{8'd0, n_pos, 1'b1, ST_OK};
                    n_pos    = n_pos + 16'd1;
                end else begin
                    fin.data = '{8'd0, r_start, 1'b1, fin_st};
                    n_pos    = r_start;
                end
                n_phase = PH_BEFORE;
                n_err   = ST_OK;
                n_start = n_pos;
            end
        end
        push0 = chr.valid ? chr : fin;
        push1 = chr.valid ? fin : t_push'('0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BEFORE;
            r_err   <= ST_OK;
            r_pos   <= '0;
            r_start <= '0;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

    qsu_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .o_data  (head),
        .i_pop   (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {head.word_position, head.out_byte};
    assign o_m_axis_tlast = head.end_of_string;
    assign o_m_axis_tuser = head.status;

endmodule

### dv/qsu_checker.sv
// Checker for the quoted string unescaper: predicts decoded words and compares the output stream.
`timescale 1ns / 1ps

module qsu_checker
    import qsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending_words
);

    t_phase      parse_phase;
    t_status     first_error;
    logic [15:0] next_pos;
    logic [15:0] string_start;
    t_result     expected_words [$];

    function automatic t_result make_word(input logic [7:0] b, input logic [15:0] pos,
                                          input logic eos, input t_status st);
        t_result r;
        r.out_byte      = b;
        r.word_position = pos;
        r.end_of_string = eos;
        r.status        = st;
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic [7:0] value;
        logic       known;
        t_status    st;
        value = 8'd0;
        known = 1'b1;
        if (first_error == ST_OK) begin
            case (parse_phase)
                PH_BEFORE: begin
                    if (c == CH_QUOTE) begin
                        parse_phase = PH_INSIDE;
                    end else if (c != CH_SPACE && c != CH_TAB) begin
                        first_error = ST_BAD_STRING;
                    end
                end
                PH_INSIDE: begin
                    if (c == CH_QUOTE) begin
                        parse_phase = PH_AFTER;
                    end else if (c == CH_BACKSLASH) begin
                        parse_phase = PH_ESCAPE;
                    end else begin
                        expected_words.push_back(make_word(c, next_pos, 1'b0, ST_OK));
                        next_pos = next_pos + 16'd1;
                    end
                end
                PH_ESCAPE: begin
                    case (c)
                        8'h61:        value = 8'd7;
                        8'h62:        value = 8'd8;
                        8'h65:        value = 8'd27;
                        8'h66:        value = 8'd12;
                        8'h6e:        value = 8'd10;
                        8'h72:        value = 8'd13;
                        8'h74:        value = 8'd9;
                        8'h76:        value = 8'd11;
                        CH_BACKSLASH: value = 8'd92;
                        CH_QUOTE:     value = 8'd34;
                        default:      known = 1'b0;
                    endcase
                    if (known) begin
                        expected_words.push_back(make_word(value, next_pos, 1'b0, ST_OK));
                        next_pos    = next_pos + 16'd1;
                        parse_phase = PH_INSIDE;
                    end else begin
                        first_error = ST_BAD_ESCAPE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (last) begin
            st = first_error;
            if (st == ST_OK && parse_phase != PH_AFTER) begin
                st = ST_BAD_STRING;
            end
            if (st == ST_OK) begin
                expected_words.push_back(make_word(8'd0, next_pos, 1'b1, ST_OK));
                next_pos = next_pos + 16'd1;
            end else begin
                expected_words.push_back(make_word(8'd0, string_start, 1'b1, st));
                next_pos = string_start;
            end
            parse_phase  = PH_BEFORE;
            first_error  = ST_OK;
            string_start = next_pos;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            parse_phase  = PH_BEFORE;
            first_error  = ST_OK;
            next_pos     = 16'd0;
            string_start = 16'd0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            // Outputs are checked before this edge's input is predicted, since a word
            // can never leave in the cycle its byte is taken.
            if (i_m_tvalid && i_m_tready) begin
                got = make_word(i_m_tdata[7:0], i_m_tdata[23:8], i_m_tlast, t_status'(i_m_tuser));
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: byte %h pos %0d last %b status %0d",
                             $time, got.out_byte, got.word_position, got.end_of_string,
                             got.status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.out_byte !== want.out_byte
                            || got.word_position !== want.word_position
                            || got.end_of_string !== want.end_of_string
                            || got.status !== want.status) begin
                        $display("%0t: word mismatch: expected byte %h pos %0d last %b status %0d",
                                 $time, want.out_byte, want.word_position, want.end_of_string,
                                 want.status);
                        $display("%0t:                actual byte %h pos %0d last %b status %0d",
                                 $time, got.out_byte, got.word_position, got.end_of_string,
                                 got.status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending_words = expected_words.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the quoted string unescaper: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import qsu_pkg::*;

    localparam logic [7:0] ESC_LETTERS [10] = '{
        8'h61, 8'h62, 8'h65, 8'h66, 8'h6e, 8'h72, 8'h74, 8'h76, CH_BACKSLASH, CH_QUOTE
    };

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;  // [7:0] in_byte
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;          // [7:0] out_byte, [23:8] word_position
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;          // [1:0] status

    logic        hold_req  = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          bytes_sent   = 0;
    int          fail_count;
    int          pending_words;
    logic [7:0]  op_text [$];

    quoted_string_unescaper_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    qsu_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_axis_tvalid),
        .i_s_tready      (o_s_axis_tready),
        .i_s_tdata       (i_s_axis_tdata),
        .i_s_tlast       (i_s_axis_tlast),
        .i_m_tvalid      (o_m_axis_tvalid),
        .i_m_tready      (i_m_axis_tready),
        .i_m_tdata       (o_m_axis_tdata),
        .i_m_tlast       (o_m_axis_tlast),
        .i_m_tuser       (o_m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending_words (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // The long hold-off lets the sender keep offering bytes until the result queue lacks room for two words.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = 64;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_text();
        foreach (op_text[k]) begin
            send_byte(op_text[k], k == op_text.size() - 1);
        end
    endtask

    // Operands are well formed or carry a bad leading byte, a bad escape, a missing
    // closing quote, or stray bytes or a backslash after the closing quote.
    task automatic random_operand();
        int         kind;
        logic [7:0] b;
        op_text.delete();
        kind = $urandom_range(99);
        repeat ($urandom_range(2)) op_text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        if (kind < 10) begin
            op_text.push_back(8'($urandom_range(255)));
        end
        op_text.push_back(CH_QUOTE);
        repeat ($urandom_range(8)) begin
            if ($urandom_range(3) == 0) begin
                op_text.push_back(CH_BACKSLASH);
                op_text.push_back(ESC_LETTERS[$urandom_range(9)]);
            end else begin
                do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
                op_text.push_back(b);
            end
        end
        if (kind >= 10 && kind < 20) begin
            op_text.push_back(CH_BACKSLASH);
            op_text.push_back(8'($urandom_range(255)));
        end
        if (kind < 30 || kind >= 40) begin
            op_text.push_back(CH_QUOTE);
        end
        if (kind >= 60 && kind < 80) begin
            repeat ($urandom_range(1, 3)) op_text.push_back(8'($urandom_range(255)));
        end
        if (kind >= 80 && kind < 85) begin
            op_text.push_back(CH_BACKSLASH);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        op_text = '{CH_SPACE, CH_TAB, CH_QUOTE, 8'h00, 8'hff, CH_BACKSLASH, 8'h6e, CH_QUOTE,
                    8'h78};
        send_text();
        op_text = '{CH_BACKSLASH, 8'h71, CH_QUOTE};
        send_text();
        op_text = '{CH_QUOTE, 8'h61, CH_BACKSLASH, 8'h7a, 8'h62};
        send_text();
        op_text = '{CH_QUOTE, 8'h63};
        send_text();
        op_text = '{CH_QUOTE, CH_QUOTE};
        send_text();
        op_text = '{CH_QUOTE, CH_BACKSLASH};
        send_text();
        op_text = '{CH_SPACE};
        send_text();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_req <= 1'b1;
                end
                1: begin
                    tx_idle_pct  = 50;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 50;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase
            while (bytes_sent < 24 + 100 * (ph + 1)) begin
                random_operand();
                send_text();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
